@@ design/ptil_pkg.sv @@
// Shared types, codes and defaults for the progress trigger block.
package ptil_pkg;

    localparam int TIME_BITS_DEF  = 47;
    localparam int COUNT_BITS_DEF = 32;
    localparam int FIFO_DEPTH_DEF = 2;

    localparam int CMD_BITS       = 3;
    localparam int MODE_BITS      = 2;
    localparam int STEP_BITS      = 32;
    localparam int GRACE_BITS     = 32;
    localparam int LIMIT_BITS     = 16;
    localparam int IDLE_RUN_BITS  = 17;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_RECORD    = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_WATERMARK = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK      = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_LATE      = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_GRACE     = 3'd4;

    // Trigger modes
    localparam logic [MODE_BITS-1:0] MODE_WALL      = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_WATERMARK = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_EVENT     = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_HYBRID    = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_MODE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROGRESS_STEP    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRACE_WINDOW     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_FIRE_ENABLE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_FIRE_LIMIT  = 3'd4;

    // Register reset values
    localparam logic [STEP_BITS-1:0]  STEP_RESET  = 32'd10000;
    localparam logic [GRACE_BITS-1:0] GRACE_RESET = 32'd5000;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd10;

    typedef struct packed {
        logic [MODE_BITS-1:0]  trigger_mode;
        logic [STEP_BITS-1:0]  progress_step;
        logic [GRACE_BITS-1:0] grace_window;
        logic                  idle_fire_enable;
        logic [LIMIT_BITS-1:0] idle_fire_limit;
    } cfg_t;

    // Decoded request class carried from front to back
    typedef struct packed {
        logic record;
        logic watermark;
        logic tick;
        logic late_hit;
        logic answer;
    } item_class_t;

endpackage

@@ design/ptil_front.sv @@
// Front end: takes requests, decodes the command and answers late and grace checks.
module ptil_front
    import ptil_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int ITEM_BITS = $bits(item_class_t) + TIME_BITS_DEF
)
(
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_BITS-1:0]  cmd,
    input  logic [TIME_BITS-1:0] time_ms,
    input  logic [TIME_BITS-1:0] ref_ms,
    input  cfg_t                 cfg,
    input  logic                 full,
    output logic                 push,
    output logic [ITEM_BITS-1:0] item
);

    logic [TIME_BITS:0] t_ext;
    logic [TIME_BITS:0] r_ext;
    logic [TIME_BITS:0] grace_ext;
    logic               late;
    logic               in_grace;
    item_class_t        cls;

    assign t_ext     = {1'b0, time_ms};
    assign r_ext     = {1'b0, ref_ms};
    assign grace_ext = (TIME_BITS + 1)'(cfg.grace_window);

    // Full-width sums: no wrap on either check
    assign late     = (ref_ms != '0) && ((t_ext + grace_ext) < r_ext);
    assign in_grace = t_ext <= (r_ext + grace_ext);

    always_comb
    begin
        cls = '0;
        unique case (cmd)
            CMD_RECORD:    cls.record    = 1'b1;
            CMD_WATERMARK: cls.watermark = 1'b1;
            CMD_TICK:      cls.tick      = 1'b1;
            CMD_LATE:
            begin
                cls.late_hit = late;
                cls.answer   = late;
            end
            CMD_GRACE:     cls.answer    = in_grace;
            default:       cls = '0;
        endcase
    end

    assign in_stall = full;
    assign push     = in_valid && !full;
    assign item     = {cls, time_ms};

endmodule

@@ design/ptil_fifo.sv @@
// Short request queue between the front end and the back end.
module ptil_fifo
    import ptil_pkg::*;
#(
    parameter int WIDTH = $bits(item_class_t) + TIME_BITS_DEF,
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/ptil_back.sv @@
// Back end: stream progress state, fire decision, counters and result register.
module ptil_back
    import ptil_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int ITEM_BITS  = $bits(item_class_t) + TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  not_empty,
    input  logic [ITEM_BITS-1:0]  item,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  fired,
    output logic                  skipped,
    output logic                  check_answer,
    output logic [TIME_BITS-1:0]  wall_time,
    output logic [TIME_BITS-1:0]  watermark_now,
    output logic [TIME_BITS-1:0]  event_time_now,
    output logic [COUNT_BITS-1:0] fire_number,
    output logic [COUNT_BITS-1:0] records_in_period,
    output logic                  idle_fire,
    output logic                  first_fire,
    output logic [COUNT_BITS-1:0] skipped_total,
    output logic [COUNT_BITS-1:0] late_total
);

    item_class_t          cls;
    logic [TIME_BITS-1:0] t;

    logic [TIME_BITS-1:0]     hi_evt_reg, hi_evt_next;
    logic [TIME_BITS-1:0]     wmark_reg, wmark_next;
    logic [TIME_BITS-1:0]     fired_wmark_reg, fired_wmark_next;
    logic [TIME_BITS-1:0]     fired_evt_reg, fired_evt_next;
    logic [COUNT_BITS-1:0]    pending_reg, pending_next;
    logic [IDLE_RUN_BITS-1:0] idle_run_reg, idle_run_next;
    logic [COUNT_BITS-1:0]    fire_cnt_reg, fire_cnt_next;
    logic [COUNT_BITS-1:0]    skip_cnt_reg, skip_cnt_next;
    logic [COUNT_BITS-1:0]    late_cnt_reg, late_cnt_next;
    logic                     out_valid_reg, out_valid_next;

    logic [TIME_BITS-1:0]     step_ext;
    logic [TIME_BITS-1:0]     wm_delta;
    logic [TIME_BITS-1:0]     evt_delta;
    logic                     wm_prog;
    logic                     evt_prog;
    logic                     go;
    logic                     idle;
    logic [IDLE_RUN_BITS-1:0] idle_run_inc;
    logic                     skip;
    logic                     do_fire;
    logic                     do_skip;

    logic                     fired_reg, skipped_reg, answer_reg;
    logic [TIME_BITS-1:0]     wall_reg, wmark_out_reg, evt_out_reg;
    logic [COUNT_BITS-1:0]    recs_out_reg;
    logic                     idle_out_reg, first_out_reg;
    logic [COUNT_BITS-1:0]    fire_out_reg, skip_out_reg, late_out_reg;

    assign {cls, t} = item;

    // Take the next request when the result register is free or being drained
    assign pop = not_empty && (!out_valid_reg || !out_stall);

    assign step_ext  = TIME_BITS'(cfg.progress_step);
    assign wm_delta  = wmark_reg - fired_wmark_reg;
    assign evt_delta = hi_evt_reg - fired_evt_reg;
    assign wm_prog   = (wmark_reg >= fired_wmark_reg) && (wm_delta >= step_ext);
    assign evt_prog  = (hi_evt_reg >= fired_evt_reg) && (evt_delta >= step_ext);

    always_comb
    begin
        unique case (cfg.trigger_mode)
            MODE_WATERMARK: go = wm_prog;
            MODE_EVENT:     go = evt_prog;
            MODE_WALL:      go = 1'b1;
            MODE_HYBRID:    go = 1'b1;
            default:        go = 1'b1;
        endcase
    end

    assign idle         = (pending_reg == '0);
    assign idle_run_inc = (idle_run_reg == '1) ? idle_run_reg
                                               : idle_run_reg + IDLE_RUN_BITS'(1);
    assign skip    = idle && (!cfg.idle_fire_enable
                             || (idle_run_inc > IDLE_RUN_BITS'(cfg.idle_fire_limit)));
    assign do_fire = cls.tick && go && !skip;
    assign do_skip = cls.tick && go && skip;

    always_comb
    begin
        hi_evt_next      = hi_evt_reg;
        wmark_next       = wmark_reg;
        fired_wmark_next = fired_wmark_reg;
        fired_evt_next   = fired_evt_reg;
        pending_next     = pending_reg;
        idle_run_next    = idle_run_reg;
        fire_cnt_next    = fire_cnt_reg;
        skip_cnt_next    = skip_cnt_reg;
        late_cnt_next    = late_cnt_reg;
        if (pop)
        begin
            if (cls.record)
            begin
                pending_next = (pending_reg == '1) ? pending_reg
                                                   : pending_reg + COUNT_BITS'(1);
                if (t > hi_evt_reg)
                begin
                    hi_evt_next = t;
                end
            end
            if (cls.watermark && (t > wmark_reg))
            begin
                wmark_next = t;
            end
            if (cls.tick && go)
            begin
                pending_next  = '0;
                idle_run_next = idle ? idle_run_inc : '0;
            end
            if (do_skip)
            begin
                skip_cnt_next = (skip_cnt_reg == '1) ? skip_cnt_reg
                                                     : skip_cnt_reg + COUNT_BITS'(1);
            end
            if (do_fire)
            begin
                fire_cnt_next    = (fire_cnt_reg == '1) ? fire_cnt_reg
                                                        : fire_cnt_reg + COUNT_BITS'(1);
                fired_wmark_next = wmark_reg;
                fired_evt_next   = hi_evt_reg;
            end
            if (cls.late_hit)
            begin
                late_cnt_next = (late_cnt_reg == '1) ? late_cnt_reg
                                                     : late_cnt_reg + COUNT_BITS'(1);
            end
        end
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_evt_reg      <= '0;
            wmark_reg       <= '0;
            fired_wmark_reg <= '0;
            fired_evt_reg   <= '0;
            pending_reg     <= '0;
            idle_run_reg    <= '0;
            fire_cnt_reg    <= '0;
            skip_cnt_reg    <= '0;
            late_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            hi_evt_reg      <= hi_evt_next;
            wmark_reg       <= wmark_next;
            fired_wmark_reg <= fired_wmark_next;
            fired_evt_reg   <= fired_evt_next;
            pending_reg     <= pending_next;
            idle_run_reg    <= idle_run_next;
            fire_cnt_reg    <= fire_cnt_next;
            skip_cnt_reg    <= skip_cnt_next;
            late_cnt_reg    <= late_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload: load on pop, hold while stalled
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            fired_reg     <= do_fire;
            skipped_reg   <= do_skip;
            answer_reg    <= cls.answer;
            wall_reg      <= do_fire ? t : '0;
            wmark_out_reg <= do_fire ? wmark_reg : '0;
            evt_out_reg   <= do_fire ? hi_evt_reg : '0;
            recs_out_reg  <= do_fire ? pending_reg : '0;
            idle_out_reg  <= do_fire && idle;
            first_out_reg <= do_fire && (fire_cnt_reg == '0);
            fire_out_reg  <= fire_cnt_next;
            skip_out_reg  <= skip_cnt_next;
            late_out_reg  <= late_cnt_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign fired             = fired_reg;
    assign skipped           = skipped_reg;
    assign check_answer      = answer_reg;
    assign wall_time         = wall_reg;
    assign watermark_now     = wmark_out_reg;
    assign event_time_now    = evt_out_reg;
    assign fire_number       = fire_out_reg;
    assign records_in_period = recs_out_reg;
    assign idle_fire         = idle_out_reg;
    assign first_fire        = first_out_reg;
    assign skipped_total     = skip_out_reg;
    assign late_total        = late_out_reg;

endmodule

@@ design/progress_trigger_with_idle_limit.sv @@
// Progress trigger with idle limit: top level.
//
// Requests enter on in_valid/in_stall with cmd, time_ms and ref_ms; each one
// gives exactly one result on out_valid/out_stall. Commands: record, watermark
// advance, timer tick, late check, grace check. A tick fires by trigger_mode,
// idle fires past idle_fire_limit, or any while idle_fire_enable is off, are
// skipped; counters saturate. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while idle, since
// the block itself does not enforce it. Throughput: one request per cycle,
// sustained while out_stall is low. The front end decodes and runs the late
// and grace compares, a two-entry queue sits in between, and the back end
// updates the stream state as each request is popped. A taken request is
// written into the queue, then popped into the result register on out_valid.
// in_stall rises only when the queue is full.
// Reset: all counters and stream clocks clear, registers take their defaults
// (wall clock mode, step 10000, grace 5000, idle fires on, limit 10).
// A stall on out_stall holds the result register; the queue fills and in_stall
// follows once it holds two requests.
module progress_trigger_with_idle_limit
    import ptil_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CMD_BITS-1:0]       cmd,
    input  logic [TIME_BITS-1:0]      time_ms,
    input  logic [TIME_BITS-1:0]      ref_ms,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      fired,
    output logic                      skipped,
    output logic                      check_answer,
    output logic [TIME_BITS-1:0]      wall_time,
    output logic [TIME_BITS-1:0]      watermark_now,
    output logic [TIME_BITS-1:0]      event_time_now,
    output logic [COUNT_BITS-1:0]     fire_number,
    output logic [COUNT_BITS-1:0]     records_in_period,
    output logic                      idle_fire,
    output logic                      first_fire,
    output logic [COUNT_BITS-1:0]     skipped_total,
    output logic [COUNT_BITS-1:0]     late_total
);

    localparam int ITEM_BITS = $bits(item_class_t) + TIME_BITS;

    cfg_t                 cfg_reg, cfg_next;
    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 not_empty;
    logic [ITEM_BITS-1:0] push_item;
    logic [ITEM_BITS-1:0] pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_MODE:     cfg_next.trigger_mode     = cfg_data[MODE_BITS-1:0];
                CFG_PROGRESS_STEP:    cfg_next.progress_step    = cfg_data[STEP_BITS-1:0];
                CFG_GRACE_WINDOW:     cfg_next.grace_window     = cfg_data[GRACE_BITS-1:0];
                CFG_IDLE_FIRE_ENABLE: cfg_next.idle_fire_enable = cfg_data[0];
                CFG_IDLE_FIRE_LIMIT:  cfg_next.idle_fire_limit  = cfg_data[LIMIT_BITS-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_mode     <= MODE_WALL;
            cfg_reg.progress_step    <= STEP_RESET;
            cfg_reg.grace_window     <= GRACE_RESET;
            cfg_reg.idle_fire_enable <= 1'b1;
            cfg_reg.idle_fire_limit  <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ptil_front #(
        .TIME_BITS (TIME_BITS),
        .ITEM_BITS (ITEM_BITS)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .time_ms  (time_ms),
        .ref_ms   (ref_ms),
        .cfg      (cfg_reg),
        .full     (full),
        .push     (push),
        .item     (push_item)
    );

    ptil_fifo #(
        .WIDTH (ITEM_BITS),
        .DEPTH (FIFO_DEPTH_DEF)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_item)
    );

    ptil_back #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS),
        .ITEM_BITS  (ITEM_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .not_empty         (not_empty),
        .item              (pop_item),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .fired             (fired),
        .skipped           (skipped),
        .check_answer      (check_answer),
        .wall_time         (wall_time),
        .watermark_now     (watermark_now),
        .event_time_now    (event_time_now),
        .fire_number       (fire_number),
        .records_in_period (records_in_period),
        .idle_fire         (idle_fire),
        .first_fire        (first_fire),
        .skipped_total     (skipped_total),
        .late_total        (late_total)
    );

endmodule

@@ design/ptil_checker.sv @@
// Port-level checks for the progress trigger, bound to the top level.
module ptil_checker
    import ptil_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  fired,
    input logic                  skipped,
    input logic                  check_answer,
    input logic [TIME_BITS-1:0]  wall_time,
    input logic [COUNT_BITS-1:0] records_in_period,
    input logic                  idle_fire,
    input logic                  first_fire,
    input logic [COUNT_BITS-1:0] fire_number
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(fired && skipped))
        else $error("tick both fired and skipped");

    // Fire fields are zero unless the tick fired
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> (wall_time == '0) && (records_in_period == '0)
                                && !idle_fire && !first_fire)
        else $error("fire fields set without a fire");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_fire |-> fire_number == COUNT_BITS'(1))
        else $error("first fire with wrong fire number");

    // Check answers only come from check requests, never from a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && check_answer |-> !fired && !skipped)
        else $error("check answer on a tick result");

endmodule

bind progress_trigger_with_idle_limit ptil_checker #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_ptil_checker (.*);

@@ test/progress_trigger_with_idle_limit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the progress trigger with idle limit block.
module progress_trigger_with_idle_limit_test
    import ptil_pkg::*;
();

    localparam int TW          = TIME_BITS_DEF;
    localparam int CW          = COUNT_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 86;
    localparam int PHASES      = 8;
    localparam int CMD_UNUSED_FIRST = CMD_GRACE + 1;
    localparam int CFG_UNUSED_FIRST = CFG_IDLE_FIRE_LIMIT + 1;
    localparam logic [TW-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic          fired;
        logic          skipped;
        logic          check_answer;
        logic [TW-1:0] wall_time;
        logic [TW-1:0] watermark_now;
        logic [TW-1:0] event_time_now;
        logic [CW-1:0] fire_number;
        logic [CW-1:0] records_in_period;
        logic          idle_fire;
        logic          first_fire;
        logic [CW-1:0] skipped_total;
        logic [CW-1:0] late_total;
    } trigger_result_t;

    class trigger_ledger;
        logic [MODE_BITS-1:0]     mode;
        logic [STEP_BITS-1:0]     step;
        logic [GRACE_BITS-1:0]    grace;
        logic                     idle_en;
        logic [LIMIT_BITS-1:0]    idle_limit;
        logic [TW-1:0]            top_event;
        logic [TW-1:0]            stream_mark;
        logic [TW-1:0]            fired_mark;
        logic [TW-1:0]            fired_event;
        logic [CW-1:0]            record_run;
        logic [IDLE_RUN_BITS-1:0] idle_run;
        logic [CW-1:0]            fires;
        logic [CW-1:0]            skips;
        logic [CW-1:0]            lates;
        trigger_result_t          owed_results[$];
        int                       mismatches;
        int                       results_checked;

        function new();
            mode = MODE_WALL;
            step = STEP_RESET;
            grace = GRACE_RESET;
            idle_en = 1'b1;
            idle_limit = LIMIT_RESET;
            top_event = '0;
            stream_mark = '0;
            fired_mark = '0;
            fired_event = '0;
            record_run = '0;
            idle_run = '0;
            fires = '0;
            skips = '0;
            lates = '0;
            mismatches = 0;
            results_checked = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_TRIGGER_MODE:     mode = data[MODE_BITS-1:0];
                CFG_PROGRESS_STEP:    step = data[STEP_BITS-1:0];
                CFG_GRACE_WINDOW:     grace = data[GRACE_BITS-1:0];
                CFG_IDLE_FIRE_ENABLE: idle_en = data[0];
                CFG_IDLE_FIRE_LIMIT:  idle_limit = data[LIMIT_BITS-1:0];
                default:              ;
            endcase
        endfunction

        function logic [CW-1:0] bump(logic [CW-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function bit moved(logic [TW-1:0] now_t, logic [TW-1:0] last_t);
            return (now_t >= last_t) && (64'(now_t) - 64'(last_t) >= 64'(step));
        endfunction

        function void note_request(logic [CMD_BITS-1:0] c, logic [TW-1:0] t,
                                   logic [TW-1:0] r);
            trigger_result_t res;
            logic            go;
            logic            idle;
            logic            skip;
            logic [CW-1:0]   recs;
            res = '0;
            case (c)
                CMD_RECORD:
                begin
                    record_run = bump(record_run);
                    if (t > top_event)
                        top_event = t;
                end
                CMD_WATERMARK:
                begin
                    if (t > stream_mark)
                        stream_mark = t;
                end
                CMD_TICK:
                begin
                    if (mode == MODE_WATERMARK)
                        go = moved(stream_mark, fired_mark);
                    else if (mode == MODE_EVENT)
                        go = moved(top_event, fired_event);
                    else
                        go = 1'b1;
                    if (go)
                    begin
                        recs = record_run;
                        idle = (recs == '0);
                        skip = 1'b0;
                        record_run = '0;
                        if (idle)
                        begin
                            if (idle_run != '1)
                                idle_run = idle_run + 1'b1;
                            if (!idle_en || idle_run > {1'b0, idle_limit})
                                skip = 1'b1;
                        end
                        else
                            idle_run = '0;
                        if (skip)
                        begin
                            skips = bump(skips);
                            res.skipped = 1'b1;
                        end
                        else
                        begin
                            fires = bump(fires);
                            fired_mark = stream_mark;
                            fired_event = top_event;
                            res.fired = 1'b1;
                            res.wall_time = t;
                            res.watermark_now = stream_mark;
                            res.event_time_now = top_event;
                            res.records_in_period = recs;
                            res.idle_fire = idle;
                            res.first_fire = (fires == 1);
                        end
                    end
                end
                CMD_LATE:
                begin
                    // a zero watermark never counts as late
                    if (r != '0 && 64'(t) + 64'(grace) < 64'(r))
                    begin
                        res.check_answer = 1'b1;
                        lates = bump(lates);
                    end
                end
                CMD_GRACE:
                    res.check_answer = (64'(t) <= 64'(r) + 64'(grace));
                default: ;
            endcase
            res.fire_number = fires;
            res.skipped_total = skips;
            res.late_total = lates;
            owed_results.insert(owed_results.size(), res);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH @%0t: %s", $time, what);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                          results_checked, name, got, want));
        endtask

        task check_result(trigger_result_t got);
            trigger_result_t want;
            if (owed_results.size() == 0)
            begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = owed_results.pop_front();
            compare_field("fired", got.fired, want.fired);
            compare_field("skipped", got.skipped, want.skipped);
            compare_field("check_answer", got.check_answer, want.check_answer);
            compare_field("wall_time", got.wall_time, want.wall_time);
            compare_field("watermark_now", got.watermark_now, want.watermark_now);
            compare_field("event_time_now", got.event_time_now, want.event_time_now);
            compare_field("fire_number", got.fire_number, want.fire_number);
            compare_field("records_in_period", got.records_in_period,
                          want.records_in_period);
            compare_field("idle_fire", got.idle_fire, want.idle_fire);
            compare_field("first_fire", got.first_fire, want.first_fire);
            compare_field("skipped_total", got.skipped_total, want.skipped_total);
            compare_field("late_total", got.late_total, want.late_total);
            results_checked++;
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [CMD_BITS-1:0]       cmd;
    logic [TW-1:0]             time_ms;
    logic [TW-1:0]             ref_ms;
    logic                      out_valid;
    logic                      out_stall;
    logic                      fired;
    logic                      skipped;
    logic                      check_answer;
    logic [TW-1:0]             wall_time;
    logic [TW-1:0]             watermark_now;
    logic [TW-1:0]             event_time_now;
    logic [CW-1:0]             fire_number;
    logic [CW-1:0]             records_in_period;
    logic                      idle_fire;
    logic                      first_fire;
    logic [CW-1:0]             skipped_total;
    logic [CW-1:0]             late_total;
    trigger_result_t           seen;

    trigger_ledger ledger;
    int            requests_sent;
    int            settings_used;
    int            gap_pct;
    int            stall_pct;
    int            stall_left;
    int            cycle_count;
    bit            quiet;
    logic [63:0]   event_clock;
    logic [63:0]   mark_clock;
    logic [63:0]   tick_clock;

    assign seen = {fired, skipped, check_answer, wall_time, watermark_now, event_time_now,
                   fire_number, records_in_period, idle_fire, first_fire, skipped_total,
                   late_total};

    progress_trigger_with_idle_limit #(
        .TIME_BITS  (TW),
        .COUNT_BITS (CW)
    ) dut (.*);

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TW-1:0] rand_time();
        return TW'({$urandom, $urandom});
    endfunction

    // Advance a stream clock by up to about half the current step.
    function automatic logic [63:0] stride();
        return ((64'($urandom) * 64'(ledger.step)) >> 33) + 64'($urandom_range(0, 7));
    endfunction

    function automatic cfg_t phase_setting(int p);
        cfg_t s;
        case (p)
            0: s = '{MODE_HYBRID, 32'd0, 32'd0, 1'b1, 16'd0};
            1: s = '{MODE_WATERMARK, 32'd10000, 32'd5000, 1'b1, 16'd3};
            2: s = '{MODE_EVENT, 32'd1000, 32'hFFFF_FFFF, 1'b0, 16'hFFFF};
            3: s = '{MODE_WATERMARK, 32'd0, 32'd1, 1'b1, 16'd1};
            4: s = '{MODE_EVENT, 32'hFFFF_FFFF, 32'd100, 1'b1, 16'd2};
            5: s = '{MODE_WALL, 32'd500, 32'd5000, 1'b0, 16'd10};
            6: s = '{MODE_EVENT, 32'd20000, 32'd2000, 1'b1, 16'hFFFF};
            default:
                s = '{MODE_BITS'($urandom_range(MODE_WALL, MODE_HYBRID)),
                      32'($urandom_range(0, 30000)), 32'($urandom),
                      1'($urandom_range(0, 1)), 16'($urandom_range(0, 12))};
        endcase
        return s;
    endfunction

    task automatic send_request(input logic [CMD_BITS-1:0] c, input logic [TW-1:0] t,
                                input logic [TW-1:0] r);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        time_ms <= t;
        ref_ms <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_request(c, t, r);
        if (c <= CMD_GRACE)
            requests_sent++;
    endtask

    // Drop valid and let every owed result come back.
    task automatic close_requests();
        in_valid <= 1'b0;
        while (ledger.owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        ledger.set_register(idx, data);
    endtask

    task automatic apply_setting(input cfg_t s);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = $urandom;
        // junk in the upper bits must be dropped by narrow registers
        write_reg(CFG_TRIGGER_MODE, {junk[CFG_DATA_BITS-1:MODE_BITS], s.trigger_mode});
        write_reg(CFG_PROGRESS_STEP, s.progress_step);
        write_reg(CFG_GRACE_WINDOW, s.grace_window);
        write_reg(CFG_IDLE_FIRE_ENABLE, {junk[CFG_DATA_BITS-1:1], s.idle_fire_enable});
        write_reg(CFG_IDLE_FIRE_LIMIT,
                  {junk[CFG_DATA_BITS-1:LIMIT_BITS], s.idle_fire_limit});
        write_reg(CFG_INDEX_BITS'(CFG_UNUSED_FIRST + $urandom_range(0, 2)), $urandom);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random();
        int          pick;
        int          n;
        logic [63:0] t;
        logic [63:0] r;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            if ($urandom_range(0, 4) == 0 && event_clock > 200)
                t = event_clock - $urandom_range(1, 200);
            else
            begin
                event_clock = event_clock + stride();
                t = event_clock;
            end
            send_request(CMD_RECORD, TW'(t), rand_time());
        end
        else if (pick < 50)
        begin
            if ($urandom_range(0, 4) == 0 && mark_clock > 200)
                t = mark_clock - $urandom_range(1, 200);
            else
            begin
                mark_clock = mark_clock + stride();
                t = mark_clock;
            end
            send_request(CMD_WATERMARK, TW'(t), rand_time());
        end
        else if (pick < 75)
        begin
            tick_clock = tick_clock + $urandom_range(0, 2000);
            send_request(CMD_TICK, TW'(tick_clock), rand_time());
        end
        else if (pick < 82)
        begin
            // run of ticks with no records to walk the idle limit
            n = $urandom_range(2, 14);
            repeat (n)
            begin
                tick_clock = tick_clock + $urandom_range(1, 1000);
                send_request(CMD_TICK, TW'(tick_clock), rand_time());
            end
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    t = rand_time();
                    r = '0;
                end
                1:
                begin
                    t = 64'(rand_time() >> 2) | 64'd1;
                    r = t + 64'(ledger.grace) + $urandom_range(0, 2) - 1;
                end
                default:
                begin
                    t = rand_time();
                    r = rand_time();
                end
            endcase
            send_request(CMD_LATE, TW'(t), TW'(r));
        end
        else if (pick < 97)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                r = 64'(rand_time() >> 2) | 64'd1;
                t = r + 64'(ledger.grace) + $urandom_range(0, 2) - 1;
            end
            else
            begin
                t = rand_time();
                r = rand_time();
            end
            send_request(CMD_GRACE, TW'(t), TW'(r));
        end
        else
            send_request(CMD_BITS'($urandom_range(CMD_UNUSED_FIRST, 2**CMD_BITS - 1)),
                         rand_time(), rand_time());
    endtask

    initial
    begin
        ledger = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_RECORD;
        time_ms = '0;
        ref_ms = '0;
        requests_sent = 0;
        settings_used = 1;
        gap_pct = 0;
        stall_pct = 0;
        quiet = 1'b0;
        event_clock = '0;
        mark_clock = '0;
        tick_clock = 64'd1000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, no register written yet
        send_request(CMD_TICK, '0, TIME_MAX);
        send_request(CMD_TICK, '0, '0);
        send_request(CMD_RECORD, TW'(100), '0);
        send_request(CMD_RECORD, '0, '0);
        send_request(CMD_WATERMARK, TW'(50), '0);
        send_request(CMD_WATERMARK, '0, '0);
        send_request(CMD_TICK, TW'(1000), '0);
        send_request(CMD_LATE, '0, '0);
        send_request(CMD_LATE, '0, TW'(GRACE_RESET) + 1'b1);
        send_request(CMD_LATE, '0, TW'(GRACE_RESET));
        send_request(CMD_LATE, TIME_MAX, TIME_MAX);
        send_request(CMD_LATE, '0, TIME_MAX);
        send_request(CMD_GRACE, TW'(GRACE_RESET), '0);
        send_request(CMD_GRACE, TW'(GRACE_RESET) + 1'b1, '0);
        send_request(CMD_GRACE, TIME_MAX, '0);
        send_request(CMD_GRACE, TIME_MAX, TIME_MAX);
        for (int c = CMD_UNUSED_FIRST; c < 2**CMD_BITS; c++)
            send_request(CMD_BITS'(c), TIME_MAX, TIME_MAX);
        close_requests();

        for (int p = 0; p < PHASES; p++)
        begin
            // keep the closing stretch free of gaps and stalls
            quiet = (p == PHASES - 1);
            apply_setting(phase_setting(p));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                begin
                    gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
                    stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
                end
                send_random();
            end
            close_requests();
        end

        // push both stream clocks to the top of their range
        write_reg(CFG_TRIGGER_MODE, CFG_DATA_BITS'(MODE_WATERMARK));
        write_reg(CFG_PROGRESS_STEP, CFG_DATA_BITS'(1));
        cfg_we <= 1'b0;
        send_request(CMD_RECORD, TIME_MAX, TIME_MAX);
        send_request(CMD_WATERMARK, TIME_MAX, TIME_MAX);
        send_request(CMD_TICK, TIME_MAX, '0);
        send_request(CMD_TICK, TIME_MAX, '0);
        send_request(CMD_LATE, '0, TIME_MAX);
        close_requests();
        repeat (8) @(posedge clk);

        if (ledger.owed_results.size() != 0)
            ledger.report_mismatch("expected results never arrived");
        $display("Ran %0d requests over %0d register settings; %0d results checked.",
                 requests_sent, settings_used, ledger.results_checked);
        $display("Expected %0d fires, %0d idle skips and %0d late hits.",
                 ledger.fires, ledger.skips, ledger.lates);
        if (ledger.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: check each taken result, then pick the next stall
    initial
    begin
        out_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                ledger.check_result(seen);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/ptil_pkg.sv
design/ptil_front.sv
design/ptil_fifo.sv
design/ptil_back.sv
design/progress_trigger_with_idle_limit.sv
design/ptil_checker.sv
test/progress_trigger_with_idle_limit_test.sv
